### hw/rtl/lda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lda_pkg: shared types and constants of the LDA token sampler
// Command codes, register indexes, fixed field widths and the control word
// of the shared divide/multiply unit.
// ----------------------------------------------------------------------------
package lda_pkg;

  // fixed field widths
  localparam int DOC_W      = 8;
  localparam int WORD_W     = 10;
  localparam int TOPIC_W    = 4;
  localparam int VAL_W      = 24;
  localparam int FRAC_W     = 16;
  localparam int PRIOR_W    = 16;
  localparam int VOCAB_W    = 11;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int TOTAL_BITS = 24;
  localparam int BV_W       = PRIOR_W + VOCAB_W;
  localparam int DEN_W      = TOTAL_BITS + 8 + 1;
  localparam int WEIGHT_W   = 32;

  // parameter defaults
  localparam int NUM_TOPICS_DEF  = 16;
  localparam int NUM_DOCS_DEF    = 256;
  localparam int VOCAB_DEPTH_DEF = 1024;
  localparam int COUNT_BITS_DEF  = 16;

  // commands
  localparam logic [CMD_W-1:0] CMD_SAMPLE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_DT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_TW  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LOAD_TOT = 2'd3;

  // configuration registers
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BETA  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOCAB = 2'd2;

  localparam logic [PRIOR_W-1:0] ALPHA_RST = 16'd256;
  localparam logic [PRIOR_W-1:0] BETA_RST  = 16'd26;
  localparam logic [VOCAB_W-1:0] VOCAB_RST = 11'd1024;

  // shared unit operations
  localparam logic ALU_DIV = 1'b0;
  localparam logic ALU_MUL = 1'b1;

  typedef struct packed {
    logic start;
    logic op;
  } alu_ctl_t;

  function automatic int addr_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/lda_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lda_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lda_ram import lda_pkg::*; #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [addr_bits(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [addr_bits(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/lda_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lda_alu: shared bit-serial divide/multiply unit
// Restoring division giving a 32-bit quotient of (opa<<16)/opb, or
// shift-add multiplication opa*opb, one bit per cycle on one adder.
// ----------------------------------------------------------------------------
module lda_alu import lda_pkg::*; #(
  parameter int HW   = 41,
  parameter int LOW  = 32,
  parameter int MULN = 25
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire alu_ctl_t      ctl,
  input  wire logic [HW-1:0] opa,
  input  wire logic [HW-1:0] opb,
  output logic               done,
  output logic [HW-1:0]      hi,
  output logic [LOW-1:0]     lo
);

  localparam int CNTW = addr_bits(LOW + 1);

  logic            run_r, run_nxt;
  logic            done_r, done_nxt;
  logic            op_r, op_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [HW-1:0]   hi_r, hi_nxt;
  logic [LOW-1:0]  lo_r, lo_nxt;
  logic [HW-1:0]   a_r, a_nxt;
  logic [HW-1:0]   b_r, b_nxt;

  logic [HW:0]     x_op, y_op;
  logic            sub;
  logic [HW+1:0]   sum;
  logic            ge;

  // one shared add/subtract
  always_comb begin
    sub  = (op_r == ALU_DIV);
    x_op = sub ? {hi_r, lo_r[LOW-1]} : {1'b0, hi_r};
    y_op = sub ? {1'b0, b_r} : (lo_r[0] ? {1'b0, a_r} : '0);
    sum  = (HW+2)'(x_op) + (sub ? ~((HW+2)'(y_op)) : (HW+2)'(y_op)) + (HW+2)'(sub);
    ge   = ~sum[HW+1];
  end

  // step control
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    if (ctl.start) begin
      run_nxt = 1'b1;
      op_nxt  = ctl.op;
      a_nxt   = opa;
      b_nxt   = opb;
      if (ctl.op == ALU_DIV) begin
        cnt_nxt = CNTW'(31);
        hi_nxt  = opa >> 16;
        lo_nxt  = LOW'({opa[15:0], 16'h0000}) << (LOW - 32);
      end else begin
        cnt_nxt = CNTW'(MULN - 1);
        hi_nxt  = '0;
        lo_nxt  = opb[LOW-1:0];
      end
    end else if (run_r) begin
      if (op_r == ALU_DIV) begin
        hi_nxt = ge ? sum[HW-1:0] : x_op[HW-1:0];
        lo_nxt = {lo_r[LOW-2:0], ge};
      end else begin
        hi_nxt = sum[HW:1];
        lo_nxt = {sum[0], lo_r[LOW-1:1]};
      end
      cnt_nxt = cnt_r - CNTW'(1);
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign done = done_r;
  assign hi   = hi_r;
  assign lo   = lo_r;

endmodule
`default_nettype wire

### hw/rtl/lda_collapsed_gibbs_token_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lda_collapsed_gibbs_token_step: one collapsed Gibbs step for LDA
// Count stores, weight pass, inverse-CDF draw and count update.
// ----------------------------------------------------------------------------
// Usage:
//  - A word is taken when start is high and busy is low. Load commands
//    (doc-topic, topic-word, topic total) write their store in that same
//    cycle; busy stays low and no result follows.
//  - A sample command raises busy until its topic is drawn. Its result,
//    out_new_topic, shows for one cycle with out_valid, as busy drops.
//    A sample with doc or word out of range is dropped without a result.
//  - A sample's run time is set by the shared bit-serial unit: per topic a
//    32-step divide and a multiply, then one multiply for the draw target.
//    It is shorter when a ratio saturates or the draw ends early.
//  - The receiver cannot stall; each result is taken in its cycle.
//  - cfg_we writes alpha, beta or vocabulary size. The user must write them
//    only while the block is idle; the block itself does not enforce it.
//  - Reset restores the priors, returns to idle and drops out_valid. The
//    count stores are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module lda_collapsed_gibbs_token_step import lda_pkg::*; #(
  parameter int NUM_TOPICS  = NUM_TOPICS_DEF,
  parameter int NUM_DOCS    = NUM_DOCS_DEF,
  parameter int VOCAB_DEPTH = VOCAB_DEPTH_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [CMD_W-1:0]     in_cmd,
  input  wire logic [DOC_W-1:0]     in_doc_index,
  input  wire logic [WORD_W-1:0]    in_word_index,
  input  wire logic [TOPIC_W-1:0]   in_topic_index,
  input  wire logic [VAL_W-1:0]     in_count_value,
  input  wire logic [FRAC_W-1:0]    in_random_fraction,
  output logic                      out_valid,
  output logic [TOPIC_W-1:0]        out_new_topic,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PRIOR_W-1:0]   cfg_wdata
);

  localparam int TW    = addr_bits(NUM_TOPICS);
  localparam int DW    = addr_bits(NUM_DOCS);
  localparam int WW    = addr_bits(VOCAB_DEPTH);
  localparam int CW    = COUNT_BITS;
  localparam int NUMW  = CW + 9;
  localparam int FACW  = CW + 9;
  localparam int SUMW  = WEIGHT_W + TW;
  localparam int MULN  = max_int(FACW, FRAC_W);
  localparam int HW    = max_int(DEN_W, max_int(SUMW, NUMW));
  localparam int LOW   = max_int(MULN, WEIGHT_W);
  localparam int PRODW = HW + MULN;
  localparam logic [32:0] CNT_MAX = (33'd1 << CW) - 33'd1;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RM_RD  = 4'd1;
  localparam logic [3:0] S_RM_WR  = 4'd2;
  localparam logic [3:0] S_T_RD   = 4'd3;
  localparam logic [3:0] S_T_CALC = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_MUL_GO = 4'd6;
  localparam logic [3:0] S_MUL    = 4'd7;
  localparam logic [3:0] S_TGT_GO = 4'd8;
  localparam logic [3:0] S_TGT    = 4'd9;
  localparam logic [3:0] S_DR_RD  = 4'd10;
  localparam logic [3:0] S_DR_CHK = 4'd11;
  localparam logic [3:0] S_AB_RD  = 4'd12;
  localparam logic [3:0] S_AB_WR  = 4'd13;

  // control registers
  logic [3:0]         state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [PRIOR_W-1:0] alpha_r, beta_r;
  logic [VOCAB_W-1:0] vocab_r;

  // payload registers
  logic [TOPIC_W-1:0] out_topic_r, out_topic_nxt;
  logic [DW-1:0]      doc_r, doc_nxt;
  logic [WW-1:0]      word_r, word_nxt;
  logic [TW-1:0]      cur_r, cur_nxt;
  logic [FRAC_W-1:0]  rf_r, rf_nxt;
  logic [BV_W-1:0]    bv_r, bv_nxt;
  logic [TW-1:0]      j_r, j_nxt;
  logic [TW-1:0]      pick_r, pick_nxt;
  logic [FACW-1:0]    fac_r, fac_nxt;
  logic [WEIGHT_W-1:0] ratio_r, ratio_nxt;
  logic [SUMW-1:0]    sum_r, sum_nxt;
  logic [SUMW-1:0]    target_r, target_nxt;
  logic [SUMW-1:0]    cum_r, cum_nxt;

  // input decode
  logic [31:0]   doc32, word32, topic32, val32;
  logic          doc_ok, word_ok, topic_ok, take;
  logic [DW-1:0] doc_in;
  logic [WW-1:0] word_in;
  logic [TW-1:0] topic_in;
  logic [CW-1:0] val_sat;

  always_comb begin
    doc32    = 32'(in_doc_index);
    word32   = 32'(in_word_index);
    topic32  = 32'(in_topic_index);
    val32    = 32'(in_count_value);
    doc_ok   = doc32 < 32'(NUM_DOCS);
    word_ok  = word32 < 32'(VOCAB_DEPTH);
    topic_ok = topic32 < 32'(NUM_TOPICS);
    doc_in   = doc32[DW-1:0];
    word_in  = word32[WW-1:0];
    topic_in = topic32[TW-1:0];
    val_sat  = ({1'b0, val32} > CNT_MAX) ? CNT_MAX[CW-1:0] : val32[CW-1:0];
    take     = start && (state_r == S_IDLE);
  end

  // store ports
  logic                  dt_we, tw_we, tot_we, wt_we;
  logic [DW+TW-1:0]      dt_waddr, dt_raddr;
  logic [TW+WW-1:0]      tw_waddr, tw_raddr;
  logic [TW-1:0]         tot_waddr, tot_raddr, rd_topic, wr_topic;
  logic [CW-1:0]         dt_wdata, dt_rd, tw_wdata, tw_rd;
  logic [TOTAL_BITS-1:0] tot_wdata, tot_rd;
  logic [WEIGHT_W-1:0]   wt_wdata, wt_rd;

  // shared unit
  alu_ctl_t       alu_ctl;
  logic [HW-1:0]  alu_a, alu_b, alu_hi;
  logic [LOW-1:0] alu_lo;
  logic           alu_done;
  logic [PRODW-1:0] prod;

  // per-topic arithmetic
  logic [NUMW-1:0]  num;
  logic [DEN_W-1:0] den;
  logic             ratio_sat;
  logic [WEIGHT_W-1:0] weight;
  logic             last_j;

  always_comb begin
    num       = NUMW'({tw_rd, 8'h00}) + NUMW'(beta_r);
    den       = DEN_W'({tot_rd, 8'h00}) + DEN_W'(bv_r);
    ratio_sat = HW'(num >> 16) >= HW'(den);
    prod      = {alu_hi, alu_lo[LOW-1 -: MULN]};
    weight    = (|prod[PRODW-1:40]) ? '1 : prod[39:8];
    last_j    = (j_r == TW'(NUM_TOPICS - 1));
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_topic_nxt = out_topic_r;
    doc_nxt       = doc_r;
    word_nxt      = word_r;
    cur_nxt       = cur_r;
    rf_nxt        = rf_r;
    bv_nxt        = bv_r;
    j_nxt         = j_r;
    pick_nxt      = pick_r;
    fac_nxt       = fac_r;
    ratio_nxt     = ratio_r;
    sum_nxt       = sum_r;
    target_nxt    = target_r;
    cum_nxt       = cum_r;
    alu_ctl       = '{start: 1'b0, op: ALU_DIV};
    alu_a         = HW'(num);
    alu_b         = HW'(den);
    wt_we         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (take && in_cmd == CMD_SAMPLE && doc_ok && word_ok) begin
          doc_nxt   = doc_in;
          word_nxt  = word_in;
          cur_nxt   = topic_in;
          rf_nxt    = in_random_fraction;
          bv_nxt    = BV_W'(beta_r * vocab_r);
          j_nxt     = '0;
          sum_nxt   = '0;
          state_nxt = topic_ok ? S_RM_RD : S_T_RD;
        end
      end
      S_RM_RD:  state_nxt = S_RM_WR;
      S_RM_WR:  state_nxt = S_T_RD;
      S_T_RD:   state_nxt = S_T_CALC;
      S_T_CALC: begin
        fac_nxt = FACW'({dt_rd, 8'h00}) + FACW'(alpha_r);
        if (ratio_sat) begin
          ratio_nxt = '1;
          state_nxt = S_MUL_GO;
        end else begin
          alu_ctl   = '{start: 1'b1, op: ALU_DIV};
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (alu_done) begin
          ratio_nxt = alu_lo[WEIGHT_W-1:0];
          state_nxt = S_MUL_GO;
        end
      end
      S_MUL_GO: begin
        alu_ctl   = '{start: 1'b1, op: ALU_MUL};
        alu_a     = HW'(ratio_r);
        alu_b     = HW'(fac_r);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (alu_done) begin
          wt_we   = 1'b1;
          sum_nxt = sum_r + SUMW'(weight);
          if (last_j) begin
            state_nxt = S_TGT_GO;
          end else begin
            j_nxt     = j_r + TW'(1);
            state_nxt = S_T_RD;
          end
        end
      end
      S_TGT_GO: begin
        alu_ctl   = '{start: 1'b1, op: ALU_MUL};
        alu_a     = HW'(sum_r);
        alu_b     = HW'(rf_r);
        state_nxt = S_TGT;
      end
      S_TGT: begin
        if (alu_done) begin
          target_nxt = prod[16 +: SUMW];
          cum_nxt    = '0;
          j_nxt      = '0;
          state_nxt  = S_DR_RD;
        end
      end
      S_DR_RD:  state_nxt = S_DR_CHK;
      S_DR_CHK: begin
        cum_nxt = cum_r + SUMW'(wt_rd);
        if (cum_nxt > target_r) begin
          pick_nxt  = j_r;
          state_nxt = S_AB_RD;
        end else if (last_j) begin
          pick_nxt  = '0;
          state_nxt = S_AB_RD;
        end else begin
          j_nxt     = j_r + TW'(1);
          state_nxt = S_DR_RD;
        end
      end
      S_AB_RD:  state_nxt = S_AB_WR;
      S_AB_WR: begin
        out_valid_nxt = 1'b1;
        out_topic_nxt = TOPIC_W'(pick_r);
        state_nxt     = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // store addressing and update
  always_comb begin
    rd_topic = j_r;
    if (state_r == S_RM_RD) begin
      rd_topic = cur_r;
    end else if (state_r == S_AB_RD) begin
      rd_topic = pick_r;
    end
    wr_topic  = (state_r == S_RM_WR) ? cur_r : pick_r;
    dt_raddr  = {doc_r, rd_topic};
    tw_raddr  = {rd_topic, word_r};
    tot_raddr = rd_topic;

    dt_we  = 1'b0;
    tw_we  = 1'b0;
    tot_we = 1'b0;
    dt_waddr  = {doc_r, wr_topic};
    tw_waddr  = {wr_topic, word_r};
    tot_waddr = wr_topic;
    dt_wdata  = dt_rd;
    tw_wdata  = tw_rd;
    tot_wdata = tot_rd;
    if (state_r == S_RM_WR) begin
      dt_we     = 1'b1;
      tw_we     = 1'b1;
      tot_we    = 1'b1;
      dt_wdata  = dt_rd - CW'(dt_rd != '0);
      tw_wdata  = tw_rd - CW'(tw_rd != '0);
      tot_wdata = tot_rd - TOTAL_BITS'(tot_rd != '0);
    end else if (state_r == S_AB_WR) begin
      dt_we     = 1'b1;
      tw_we     = 1'b1;
      tot_we    = 1'b1;
      dt_wdata  = dt_rd + CW'(dt_rd != '1);
      tw_wdata  = tw_rd + CW'(tw_rd != '1);
      tot_wdata = tot_rd + TOTAL_BITS'(tot_rd != '1);
    end else if (take) begin
      dt_waddr  = {doc_in, topic_in};
      tw_waddr  = {topic_in, word_in};
      tot_waddr = topic_in;
      dt_wdata  = val_sat;
      tw_wdata  = val_sat;
      tot_wdata = in_count_value;
      dt_we     = (in_cmd == CMD_LOAD_DT) && doc_ok && topic_ok;
      tw_we     = (in_cmd == CMD_LOAD_TW) && word_ok && topic_ok;
      tot_we    = (in_cmd == CMD_LOAD_TOT) && topic_ok;
    end
    wt_wdata = weight;
  end

  lda_ram #(.WIDTH(CW), .DEPTH(1 << (DW + TW))) u_dt_ram (
    .clk(clk), .we(dt_we), .waddr(dt_waddr), .wdata(dt_wdata),
    .raddr(dt_raddr), .rdata(dt_rd)
  );

  lda_ram #(.WIDTH(CW), .DEPTH(1 << (TW + WW))) u_tw_ram (
    .clk(clk), .we(tw_we), .waddr(tw_waddr), .wdata(tw_wdata),
    .raddr(tw_raddr), .rdata(tw_rd)
  );

  lda_ram #(.WIDTH(TOTAL_BITS), .DEPTH(1 << TW)) u_tot_ram (
    .clk(clk), .we(tot_we), .waddr(tot_waddr), .wdata(tot_wdata),
    .raddr(tot_raddr), .rdata(tot_rd)
  );

  lda_ram #(.WIDTH(WEIGHT_W), .DEPTH(1 << TW)) u_wt_ram (
    .clk(clk), .we(wt_we), .waddr(j_r), .wdata(wt_wdata),
    .raddr(j_r), .rdata(wt_rd)
  );

  lda_alu #(.HW(HW), .LOW(LOW), .MULN(MULN)) u_alu (
    .clk(clk), .rst_n(rst_n), .ctl(alu_ctl), .opa(alu_a), .opb(alu_b),
    .done(alu_done), .hi(alu_hi), .lo(alu_lo)
  );

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      alpha_r     <= ALPHA_RST;
      beta_r      <= BETA_RST;
      vocab_r     <= VOCAB_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_ALPHA: alpha_r <= cfg_wdata;
          REG_BETA:  beta_r  <= cfg_wdata;
          REG_VOCAB: vocab_r <= cfg_wdata[VOCAB_W-1:0];
          default:   ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    out_topic_r <= out_topic_nxt;
    doc_r       <= doc_nxt;
    word_r      <= word_nxt;
    cur_r       <= cur_nxt;
    rf_r        <= rf_nxt;
    bv_r        <= bv_nxt;
    j_r         <= j_nxt;
    pick_r      <= pick_nxt;
    fac_r       <= fac_nxt;
    ratio_r     <= ratio_nxt;
    sum_r       <= sum_nxt;
    target_r    <= target_nxt;
    cum_r       <= cum_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_new_topic = out_topic_r;

endmodule
`default_nettype wire

### hw/rtl/lda_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lda_chk: port-level checks for the LDA token sampler
// Watches the command and result ports over time.
// ----------------------------------------------------------------------------
module lda_chk import lda_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic [CMD_W-1:0]   in_cmd,
  input wire logic               out_valid
);

  // reset leaves the block idle and silent
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> (!busy && !out_valid))
    else $error("block not idle after reset");

  // a result is a single-cycle strobe
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result held longer than one cycle");

  // a result ends a busy phase
  a_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result without a preceding sample");

  // loads complete in the accepting cycle
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd != CMD_SAMPLE) |=> (!busy && !out_valid))
    else $error("load command raised busy or a result");

endmodule

bind lda_collapsed_gibbs_token_step lda_chk u_lda_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .in_cmd(in_cmd), .out_valid(out_valid)
);
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the LDA collapsed Gibbs token sampler
// Loads the count stores, then runs sample words under several prior settings
// and idle patterns. Each drawn topic is checked against a local Q16.16
// prediction of the weight pass and the inverse-CDF draw.
// ----------------------------------------------------------------------------
module tb;
  import lda_pkg::*;

  localparam int  NT         = 16;
  localparam int  SETTLE     = 1200;
  localparam int  LIMIT      = 8000000;
  localparam int  N_RANDOM   = 1150;
  localparam int  MAX_PRINTS = 40;

  typedef enum logic [1:0] {K_ITEM, K_CFG, K_DRAIN, K_IDLE} entry_kind_e;

  typedef struct {
    entry_kind_e           kind;
    logic [CMD_W-1:0]      cmd;
    logic [DOC_W-1:0]      doc;
    logic [WORD_W-1:0]     word;
    logic [TOPIC_W-1:0]    topic;
    logic [VAL_W-1:0]      val;
    logic [FRAC_W-1:0]     frac;
    logic [CFG_IDX_W-1:0]  idx;
    logic [PRIOR_W-1:0]    data;
    int                    arg;
  } entry_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [CMD_W-1:0]     in_cmd = '0;
  logic [DOC_W-1:0]     in_doc_index = '0;
  logic [WORD_W-1:0]    in_word_index = '0;
  logic [TOPIC_W-1:0]   in_topic_index = '0;
  logic [VAL_W-1:0]     in_count_value = '0;
  logic [FRAC_W-1:0]    in_random_fraction = '0;
  logic                 out_valid;
  logic [TOPIC_W-1:0]   out_new_topic;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PRIOR_W-1:0]   cfg_wdata = '0;

  lda_collapsed_gibbs_token_step uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_doc_index(in_doc_index), .in_word_index(in_word_index),
    .in_topic_index(in_topic_index), .in_count_value(in_count_value),
    .in_random_fraction(in_random_fraction),
    .out_valid(out_valid), .out_new_topic(out_new_topic),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of priors and count stores
  logic [15:0] alpha_q = ALPHA_RST;
  logic [15:0] beta_q  = BETA_RST;
  logic [10:0] vocab_q = VOCAB_RST;
  logic [15:0] doc_cnt  [0:4095];
  logic [15:0] word_cnt [0:16383];
  logic [23:0] tot_cnt  [0:NT-1];

  entry_t          pending_q[$];
  logic [3:0]      topic_q[$];
  int              err_count = 0;
  int              n_samples = 0, n_loads = 0, n_cfg = 0, n_topics = 0;
  int              cycles = 0;

  // working set of documents and words used by the generator
  logic [7:0]      ws_docs  [0:5] = '{8'h00, 8'h55, 8'hAA, 8'hFF, 8'h0F, 8'hF0};
  logic [9:0]      ws_words [0:5] = '{10'h000, 10'h155, 10'h2AA, 10'h3FF, 10'h0F0, 10'h30F};

  task automatic report(input string msg);
    if (err_count < MAX_PRINTS)
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic logic [31:0] topic_weight(input logic [15:0] wc, input logic [23:0] tot,
                                               input logic [15:0] dc);
    logic [63:0] num, den, ratio, fac, prod;
    num = ({48'd0, wc} << 8) + {48'd0, beta_q};
    den = ({40'd0, tot} << 8) + {48'd0, beta_q} * {53'd0, vocab_q};
    ratio = (den != 0) ? (num << 16) / den : 64'hFFFF_FFFF;
    if (ratio > 64'hFFFF_FFFF) ratio = 64'hFFFF_FFFF;
    fac = ({48'd0, dc} << 8) + {48'd0, alpha_q};
    prod = (ratio * fac) >> 8;
    return (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
  endfunction

  // remove the token, draw by inverse CDF, add it back under the drawn topic
  function automatic logic [3:0] draw_topic(input logic [7:0] doc, input logic [9:0] word,
                                            input logic [3:0] cur, input logic [15:0] frac);
    logic [31:0] w [0:NT-1];
    logic [63:0] sum, target, cum;
    logic [3:0]  pick;
    logic        found;
    sum = 0;
    cum = 0;
    pick = '0;
    found = 1'b0;
    if (doc_cnt[{doc, cur}] != 0) doc_cnt[{doc, cur}]--;
    if (word_cnt[{cur, word}] != 0) word_cnt[{cur, word}]--;
    if (tot_cnt[cur] != 0) tot_cnt[cur]--;
    for (int j = 0; j < NT; j++) begin
      w[j] = topic_weight(word_cnt[{j[3:0], word}], tot_cnt[j], doc_cnt[{doc, j[3:0]}]);
      sum += {32'd0, w[j]};
    end
    target = (sum * {48'd0, frac}) >> 16;
    for (int j = 0; j < NT; j++) begin
      cum += {32'd0, w[j]};
      if (!found && cum > target) begin
        pick = j[3:0];
        found = 1'b1;
      end
    end
    if (doc_cnt[{doc, pick}] != 16'hFFFF) doc_cnt[{doc, pick}]++;
    if (word_cnt[{pick, word}] != 16'hFFFF) word_cnt[{pick, word}]++;
    if (tot_cnt[pick] != 24'hFF_FFFF) tot_cnt[pick]++;
    return pick;
  endfunction

  task automatic apply_word(input entry_t e);
    case (e.cmd)
      CMD_LOAD_DT: doc_cnt[{e.doc, e.topic}] = (e.val > 24'hFFFF) ? 16'hFFFF : e.val[15:0];
      CMD_LOAD_TW: word_cnt[{e.topic, e.word}] = (e.val > 24'hFFFF) ? 16'hFFFF : e.val[15:0];
      CMD_LOAD_TOT: tot_cnt[e.topic] = e.val;
      default: begin
        topic_q.push_back(draw_topic(e.doc, e.word, e.topic, e.frac));
        n_samples++;
      end
    endcase
    if (e.cmd != CMD_SAMPLE) n_loads++;
  endtask

  task automatic push_word(input logic [1:0] cmd, input logic [7:0] doc, input logic [9:0] word,
                           input logic [3:0] topic, input logic [23:0] val,
                           input logic [15:0] frac);
    entry_t e;
    e = '{kind: K_ITEM, cmd: cmd, doc: doc, word: word, topic: topic, val: val, frac: frac,
          idx: '0, data: '0, arg: 0};
    pending_q.push_back(e);
  endtask

  task automatic push_ctl(input entry_kind_e kind, input logic [1:0] idx,
                          input logic [15:0] data, input int arg);
    entry_t e;
    e = '{kind: kind, cmd: CMD_SAMPLE, doc: '0, word: '0, topic: '0, val: '0, frac: '0,
          idx: idx, data: data, arg: arg};
    pending_q.push_back(e);
  endtask

  // hold a settled block, then write all three priors
  task automatic push_priors(input logic [15:0] a, input logic [15:0] b, input logic [15:0] v);
    push_ctl(K_DRAIN, '0, '0, SETTLE);
    push_ctl(K_CFG, REG_ALPHA, a, 0);
    push_ctl(K_CFG, REG_BETA, b, 0);
    push_ctl(K_CFG, REG_VOCAB, v, 0);
  endtask

  function automatic logic [23:0] rand_count();
    case ($urandom_range(0, 5))
      0: return 24'd0;
      1: return 24'hFFFF;
      2: return 24'($urandom_range(0, 24'hFF_FFFF));
      default: return 24'($urandom_range(0, 60));
    endcase
  endfunction

  // driver: hold start until taken, then pop the next word or control entry
  entry_t cur_e;
  int     idle_pct = 0;
  int     hold = 0;
  logic   draining = 1'b0;
  always @(posedge clk) begin
    logic   taken, start_nx, we_nx;
    entry_t e;
    cycles++;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) apply_word(cur_e);
      start_nx = start && !taken;
      we_nx = 1'b0;
      if (!start_nx) begin
        if (hold > 0) begin
          hold--;
        end else if (draining) begin
          if (topic_q.size() == 0) draining = 1'b0;
        end else if (pending_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          e = pending_q.pop_front();
          case (e.kind)
            K_ITEM: begin
              cur_e = e;
              start_nx = 1'b1;
              in_cmd <= e.cmd;
              in_doc_index <= e.doc;
              in_word_index <= e.word;
              in_topic_index <= e.topic;
              in_count_value <= e.val;
              in_random_fraction <= e.frac;
            end
            K_CFG: begin
              we_nx = 1'b1;
              cfg_index <= e.idx;
              cfg_wdata <= e.data;
              n_cfg++;
              case (e.idx)
                REG_ALPHA: alpha_q = e.data;
                REG_BETA: beta_q = e.data;
                REG_VOCAB: vocab_q = e.data[10:0];
                default: ;
              endcase
            end
            K_DRAIN: begin
              draining = 1'b1;
              hold = e.arg;
            end
            default: idle_pct = e.arg;
          endcase
        end
      end
      start <= start_nx;
      cfg_we <= we_nx;
    end
  end

  // monitor: compare each drawn topic with the oldest prediction
  always @(posedge clk) begin
    logic [3:0] want;
    if (rst_n && out_valid) begin
      n_topics++;
      if (topic_q.size() == 0) begin
        report($sformatf("unexpected topic %0d", out_new_topic));
      end else begin
        want = topic_q.pop_front();
        if (out_new_topic !== want)
          report($sformatf("new_topic got %0d want %0d", out_new_topic, want));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [1:0]  cmd;
    logic [15:0] a, b, v;
    int          pick;
    int          idle_list [0:3];

    idle_list = '{0, 60, 0, 25};

    // fill the working set under reset priors
    for (int d = 0; d < 6; d++)
      for (int t = 0; t < NT; t++)
        push_word(CMD_LOAD_DT, ws_docs[d], '0, TOPIC_W'(t), rand_count(), '0);
    for (int w = 0; w < 6; w++)
      for (int t = 0; t < NT; t++)
        push_word(CMD_LOAD_TW, '0, ws_words[w], TOPIC_W'(t), rand_count(), '0);
    for (int t = 0; t < NT; t++)
      push_word(CMD_LOAD_TOT, '0, '0, TOPIC_W'(t), VAL_W'($urandom_range(0, 3000)), '0);

    // reset priors, fraction extremes and saturated counts
    push_word(CMD_SAMPLE, 8'h00, 10'h000, 4'd0, 24'hFF_FFFF, 16'h0000);
    push_word(CMD_SAMPLE, 8'hFF, 10'h3FF, 4'd15, 24'h0, 16'hFFFF);
    push_word(CMD_LOAD_DT, 8'h55, '0, 4'd7, 24'hFF_FFFF, '0);
    push_word(CMD_LOAD_TW, '0, 10'h155, 4'd7, 24'h01_0000, '0);
    push_word(CMD_LOAD_TOT, '0, '0, 4'd7, 24'hFF_FFFF, '0);
    push_word(CMD_SAMPLE, 8'h55, 10'h155, 4'd7, 24'h0, 16'h8000);

    // zero priors: empty doc row gives all-zero weights, empty total a zero denominator
    push_priors(16'd0, 16'd0, 16'd1);
    for (int t = 0; t < NT; t++) push_word(CMD_LOAD_DT, 8'h0F, '0, TOPIC_W'(t), 24'd0, '0);
    push_word(CMD_LOAD_TOT, '0, '0, 4'd3, 24'd0, '0);
    push_word(CMD_SAMPLE, 8'h0F, 10'h0F0, 4'd2, 24'h0, 16'h0000);
    push_word(CMD_SAMPLE, 8'h0F, 10'h2AA, 4'd9, 24'h0, 16'hFFFF);
    push_word(CMD_SAMPLE, 8'h00, 10'h30F, 4'd3, 24'h0, 16'h1234);
    push_ctl(K_DRAIN, '0, '0, 0);

    // random phases, each with its own priors and idle pattern
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin a = 16'hFFFF; b = 16'hFFFF; v = 16'd1024; end
        1: begin a = 16'd256;  b = 16'd26;   v = 16'd1024; end
        2: begin a = 16'd0;    b = 16'd1;    v = 16'd1;    end
        default: begin
          a = 16'($urandom_range(0, 16'hFFFF));
          b = 16'($urandom_range(0, 2000));
          v = 16'($urandom_range(1, 1024));
        end
      endcase
      push_priors(a, b, v);
      push_ctl(K_IDLE, '0, '0, idle_list[ph % 4]);
      for (int i = 0; i < N_RANDOM / 5; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          push_word(CMD_SAMPLE, ws_docs[$urandom_range(0, 5)], ws_words[$urandom_range(0, 5)],
                    TOPIC_W'($urandom_range(0, 15)), VAL_W'($urandom_range(0, 24'hFF_FFFF)),
                    FRAC_W'($urandom_range(0, 16'hFFFF)));
        end else if (pick < 75) begin
          cmd = CMD_W'($urandom_range(1, 3));
          push_word(cmd, ws_docs[$urandom_range(0, 5)], ws_words[$urandom_range(0, 5)],
                    TOPIC_W'($urandom_range(0, 15)), rand_count(),
                    FRAC_W'($urandom_range(0, 16'hFFFF)));
        end else begin
          // scattered loads at random indexes, which may also land in the working set
          cmd = CMD_W'($urandom_range(1, 3));
          push_word(cmd, DOC_W'($urandom_range(0, 255)), WORD_W'($urandom_range(0, 1023)),
                    TOPIC_W'($urandom_range(0, 15)), VAL_W'($urandom_range(0, 24'hFF_FFFF)),
                    FRAC_W'($urandom_range(0, 16'hFFFF)));
        end
        if (i == 100) push_ctl(K_DRAIN, '0, '0, 0);
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() > 0 || start || draining || hold > 0 || topic_q.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    while (topic_q.size() > 0) begin
      report("predicted topic never returned");
      void'(topic_q.pop_front());
    end

    $display("Ran %0d samples and %0d loads with %0d prior writes; %0d topics checked.",
             n_samples, n_loads, n_cfg, n_topics);
    $display("Covered zero and full-scale priors, empty rows, saturating counts, idle gaps.");
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
